// File: hdl/bts_pkg.sv
// bts_pkg: types, constants and the tone table of the buzzer tone sequencer
// used by bts_player and buzzer_tone_sequencer; no dependencies
`default_nettype none

package bts_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SEQ_MAX     = 3;
    localparam int LOAD_N      = (QUEUE_DEPTH < SEQ_MAX) ? QUEUE_DEPTH : SEQ_MAX;
    localparam int IDX_W       = $clog2(LOAD_N);

    localparam int HZ_W  = 10;
    localparam int MS_W  = 9;
    localparam int POS_W = 2;
    localparam int CNT_W = 2;
    localparam int MEL_W = 3;

    localparam logic [MS_W-1:0] ELAPSED_MAX = 9'd511;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_PRESET    = 2'd1,
        CMD_TIMER     = 2'd2,
        CMD_COUNTDOWN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_WORK       = 2'd0,
        MODE_BREAK      = 2'd1,
        MODE_LONG_BREAK = 2'd2,
        MODE_OTHER      = 2'd3
    } t_mode;

    typedef enum logic [MEL_W-1:0] {
        MEL_WORK_END   = 3'd0,
        MEL_BREAK_END  = 3'd1,
        MEL_CHIME      = 3'd2,
        MEL_BEEP       = 3'd3,
        MEL_TICK       = 3'd4,
        MEL_FINAL      = 3'd5,
        MEL_NONE       = 3'd6
    } t_mel;

    localparam logic [0:0] REG_SOUND_EN = 1'd0;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        logic [SEQ_MAX-1:0][HZ_W-1:0] hz;
        logic [SEQ_MAX-1:0][MS_W-1:0] ms;
    } t_melody;

    typedef struct packed {
        logic valid;
        logic is_tick;
        t_mel mel;
    } t_req;

    typedef struct packed {
        logic [HZ_W-1:0] tone_hz;
        logic            sounding;
        logic            accepted;
    } t_res;

    function automatic t_melody melody_of(input t_mel m);
        t_melody r;
        r = '0;
        unique case (m)
            MEL_WORK_END: begin
                r.count = 2'd3;
                r.hz = {10'd784, 10'd659, 10'd523};
                r.ms = {9'd280, 9'd250, 9'd250};
            end
            MEL_BREAK_END: begin
                r.count = 2'd3;
                r.hz = {10'd523, 10'd659, 10'd784};
                r.ms = {9'd280, 9'd250, 9'd250};
            end
            MEL_CHIME: begin
                r.count = 2'd3;
                r.hz = {10'd784, 10'd659, 10'd523};
                r.ms = {9'd200, 9'd150, 9'd150};
            end
            MEL_BEEP: begin
                r.count = 2'd1;
                r.hz[0] = 10'd880;
                r.ms[0] = 9'd100;
            end
            MEL_TICK: begin
                r.count = 2'd1;
                r.hz[0] = 10'd880;
                r.ms[0] = 9'd50;
            end
            MEL_FINAL: begin
                r.count = 2'd2;
                r.hz = {10'd0, 10'd880, 10'd880};
                r.ms = {9'd0, 9'd200, 9'd100};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_mel melody_select(input t_cmd cmd, input logic [1:0] kind,
                                           input t_mode mode, input logic rem);
        t_mel r;
        r = MEL_NONE;
        unique case (cmd)
            CMD_TICK:      r = MEL_NONE;
            CMD_PRESET:    r = t_mel'({1'b0, kind});
            CMD_TIMER: begin
                unique case (mode)
                    MODE_WORK:       r = MEL_BREAK_END;
                    MODE_BREAK:      r = MEL_WORK_END;
                    MODE_LONG_BREAK: r = MEL_WORK_END;
                    MODE_OTHER:      r = MEL_NONE;
                    default:         r = MEL_NONE;
                endcase
            end
            CMD_COUNTDOWN: r = rem ? MEL_TICK : MEL_FINAL;
            default:       r = MEL_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bts_player.sv
// bts_player: tone stores, position and elapsed counters of the sequencer
// depends on bts_pkg
`default_nettype none

module bts_player
    import bts_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_sound_en,
    input  t_req i_req,
    output t_res o_res
);

    logic [LOAD_N-1:0][HZ_W-1:0] r_freq;
    logic [LOAD_N-1:0][MS_W-1:0] r_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_seq_len, n_seq_len;
    logic [MS_W-1:0]  r_elapsed, n_elapsed;
    logic             r_playing, n_playing;

    t_melody          mel;
    logic             can_start;
    logic [MS_W-1:0]  el_inc;
    logic [POS_W:0]   pos_next;

    always_comb begin
        mel       = melody_of(i_req.mel);
        can_start = !i_req.is_tick && i_sound_en && !r_playing
                    && (mel.count != '0) && (int'(mel.count) <= QUEUE_DEPTH);
        el_inc    = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        pos_next  = {1'b0, r_pos} + 1'b1;

        n_pos     = r_pos;
        n_seq_len = r_seq_len;
        n_elapsed = r_elapsed;
        n_playing = r_playing;

        if (i_req.valid) begin
            if (can_start) begin
                n_playing = 1'b1;
                n_seq_len = mel.count;
                n_pos     = '0;
                n_elapsed = '0;
            end else if (i_req.is_tick && r_playing) begin
                if (el_inc < r_len[IDX_W'(r_pos)]) begin
                    n_elapsed = el_inc;
                end else if (pos_next < {1'b0, r_seq_len}) begin
                    n_pos     = pos_next[POS_W-1:0];
                    n_elapsed = '0;
                end else begin
                    n_playing = 1'b0;
                    n_seq_len = '0;
                    n_pos     = '0;
                    n_elapsed = '0;
                end
            end
        end

        o_res.sounding = n_playing;
        o_res.accepted = i_req.valid && can_start;
        if (!n_playing) begin
            o_res.tone_hz = '0;
        end else if (i_req.valid && can_start) begin
            o_res.tone_hz = mel.hz[0];
        end else begin
            o_res.tone_hz = r_freq[IDX_W'(n_pos)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_seq_len <= '0;
            r_elapsed <= '0;
            r_playing <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_seq_len <= n_seq_len;
            r_elapsed <= n_elapsed;
            r_playing <= n_playing;
        end
    end

    // tone stores, loaded on a started sequence
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LOAD_N; i++) begin
            if (i_req.valid && can_start && (i < int'(mel.count))) begin
                r_freq[i] <= mel.hz[i];
                r_len[i]  <= mel.ms[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/buzzer_tone_sequencer.sv
// buzzer_tone_sequencer: top level with stream ports, apb register and result register
// depends on bts_pkg and bts_player
//
// One result comes out for every transaction taken: a one-millisecond tick (cmd 0) or a
// sound request (cmd 1..3). State updates at the edge a transaction is accepted and
// its result sits in the output register from the next cycle. s_tready stays high
// while the output register is empty or being drained, so a new transaction can enter
// every cycle. The apb register at paddr[2] = 0 (bit 0) enables sound, reset 1.
`default_nettype none

module buzzer_tone_sequencer
    import bts_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // sound_kind[1:0], timer_mode[3:2], remaining_positive[4]
    input  wire  [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // tone_hz[9:0], sounding[10], accepted[11]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic r_sound_en;
    logic r_m_valid;
    t_res r_res;
    t_req req;
    t_res res;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, r_sound_en};
    assign s_tready = !r_m_valid || m_tready;

    always_comb begin
        req.valid   = s_tvalid && s_tready;
        req.is_tick = (t_cmd'(s_tuser) == CMD_TICK);
        req.mel     = melody_select(t_cmd'(s_tuser), s_tdata[1:0],
                                    t_mode'(s_tdata[3:2]), s_tdata[4]);
    end

    bts_player u_player (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sound_en (r_sound_en),
        .i_req      (req),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_en <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SOUND_EN)) begin
            r_sound_en <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (req.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.valid) begin
            r_res <= res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'd0, r_res.accepted, r_res.sounding, r_res.tone_hz};

endmodule

`default_nettype wire
